FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Clocked property checks, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge while reset is released
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// check on every rising edge, reset included
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Token codes, result codes, microcode word layout and control program of
// the infix to postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  // input token kinds
  localparam logic [1:0] TOK_NUM  = 2'd0;
  localparam logic [1:0] TOK_VAR  = 2'd1;
  localparam logic [1:0] TOK_FUNC = 2'd2;
  localparam logic [1:0] TOK_OPER = 2'd3;

  // operator codes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_LPAR = 3'd5;
  localparam logic [2:0] OP_RPAR = 3'd6;

  // highest valid function code
  localparam logic [3:0] FN_MAX = 4'd8;

  // result kinds
  localparam logic [2:0] KIND_NUM  = 3'd0;
  localparam logic [2:0] KIND_VAR  = 3'd1;
  localparam logic [2:0] KIND_OPER = 3'd2;
  localparam logic [2:0] KIND_FUNC = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_CLOSE    = 2'd2;
  localparam logic [1:0] ERR_OPEN     = 2'd3;

  // results per item are capped
  typedef logic [5:0] rcnt_t;
  localparam rcnt_t MAX_RESULTS = 6'd33;

  // stack entry: bit 4 marks a function, low bits hold the code
  typedef logic [4:0] entry_t;
  localparam int unsigned ENTRY_BITS = 5;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_OPND,
    CLS_FUNC,
    CLS_BIN,
    CLS_LPAR,
    CLS_RPAR
  } cls_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_EMPTY,
    C_TOP_LPAR,
    C_TOP_FN,
    C_BIN_POPS,
    C_LAST
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_EMIT_IN,
    A_PUSH_FN,
    A_PUSH_OP,
    A_POP_EMIT,
    A_POP_DROP,
    A_POP_ERR3,
    A_ERR2,
    A_DONE,
    A_END
  } act_t;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_OPND  = 4'd1;
  localparam step_t S_FUNC  = 4'd2;
  localparam step_t S_BIN   = 4'd3;
  localparam step_t S_LPAR  = 4'd4;
  localparam step_t S_RPAR  = 4'd5;
  localparam step_t S_RPOP  = 4'd6;
  localparam step_t S_RFN   = 4'd7;
  localparam step_t S_TAIL  = 4'd8;
  localparam step_t S_FLUSH = 4'd9;
  localparam step_t S_FPOP  = 4'd10;
  localparam step_t S_END   = 4'd11;

  typedef struct packed {
    cond_t cond;
    act_t  act_hit;
    step_t step_hit;
    act_t  act_miss;
    step_t step_miss;
  } uword_t;

  typedef struct packed {
    logic idle;
    act_t act;
  } ctrl_t;

  typedef struct packed {
    cls_t in_cls;
    logic accept;
    logic empty;
    logic top_lpar;
    logic top_fn;
    logic bin_pops;
    logic last;
    logic hold;
  } stat_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{C_ALWAYS, A_NONE, S_IDLE, A_NONE, S_IDLE};
    case (s)
      S_IDLE:  w = '{C_ALWAYS,   A_NONE,     S_IDLE,  A_NONE,     S_IDLE};
      S_OPND:  w = '{C_ALWAYS,   A_EMIT_IN,  S_TAIL,  A_EMIT_IN,  S_TAIL};
      S_FUNC:  w = '{C_ALWAYS,   A_PUSH_FN,  S_TAIL,  A_PUSH_FN,  S_TAIL};
      S_BIN:   w = '{C_BIN_POPS, A_POP_EMIT, S_BIN,   A_PUSH_OP,  S_TAIL};
      S_LPAR:  w = '{C_ALWAYS,   A_PUSH_OP,  S_TAIL,  A_PUSH_OP,  S_TAIL};
      S_RPAR:  w = '{C_EMPTY,    A_ERR2,     S_TAIL,  A_NONE,     S_RPOP};
      S_RPOP:  w = '{C_TOP_LPAR, A_POP_DROP, S_RFN,   A_POP_EMIT, S_RPAR};
      S_RFN:   w = '{C_TOP_FN,   A_POP_EMIT, S_TAIL,  A_NONE,     S_TAIL};
      S_TAIL:  w = '{C_LAST,     A_NONE,     S_FLUSH, A_DONE,     S_IDLE};
      S_FLUSH: w = '{C_EMPTY,    A_NONE,     S_END,   A_NONE,     S_FPOP};
      S_FPOP:  w = '{C_TOP_LPAR, A_POP_ERR3, S_FLUSH, A_POP_EMIT, S_FLUSH};
      S_END:   w = '{C_ALWAYS,   A_END,      S_IDLE,  A_END,      S_IDLE};
      default: w = '{C_ALWAYS,   A_NONE,     S_IDLE,  A_NONE,     S_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t entry_step(input cls_t c);
    step_t s;
    case (c)
      CLS_OPND: s = S_OPND;
      CLS_FUNC: s = S_FUNC;
      CLS_BIN:  s = S_BIN;
      CLS_LPAR: s = S_LPAR;
      CLS_RPAR: s = S_RPAR;
      default:  s = S_TAIL;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: one infix token per input item, postfix tokens
// out, driven by a microcoded sequencer over a RAM-based operator stack.
//
// Input channel in_*: valid/stall; one token per item, in_last on the final
// token of an expression. Output channel out_*: valid/stall; one postfix
// token per item, out_end_res on the final result of the expression, and
// out_error carrying the sticky error code at emission time (final result:
// error of the whole expression).
// Timing: the sequencer takes one item at a time and takes no new token
// until it has finished the last one. An operand is emitted; a function
// or '(' is pushed; a binary operator pops each entry that it yields to,
// then is pushed; ')' pops up to and including its '(', then a function
// below it. A last token then flushes the stack. One step of the control
// program runs per cycle unless a stalled output holds it, and each pop
// reads the stack RAM once. A result leaves the datapath one emission late,
// when the next one is produced or the item ends.
// Reset: stack emptied, error cleared, output invalid; no clearing pass.
// A stalled output holds its item; the sequencer waits in the step that
// needs the output register until it frees.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_func,
  input  logic [2:0]             in_op_code,
  input  logic [3:0]             in_fn_code,
  input  logic [HANDLE_BITS-1:0] in_operand,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_kind,
  output logic [2:0]             out_op,
  output logic [3:0]             out_fn,
  output logic [HANDLE_BITS-1:0] out_operand,
  output logic                   out_end_res,
  output logic [1:0]             out_error
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  i2p_pkg::ctrl_t  ctrl;
  i2p_pkg::stat_t  stat;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  i2p_pkg::entry_t ram_wdata;
  logic [AW-1:0]   ram_raddr;
  i2p_pkg::entry_t ram_rdata;

  i2p_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  i2p_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_op_code  (in_op_code),
    .in_fn_code  (in_fn_code),
    .in_operand  (in_operand),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_op      (out_op),
    .out_fn      (out_fn),
    .out_operand (out_operand),
    .out_end_res (out_end_res),
    .out_error   (out_error),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  i2p_ram #(
    .WIDTH (i2p_pkg::ENTRY_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: rtl/i2p_ram.sv
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2p_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/i2p_seq.sv
// ----------------------------------------------------------------------------
// i2p_seq
// Microcode sequencer: step counter, control store lookup and two-way
// conditional branch; issues one action per step to the datapath.
// ----------------------------------------------------------------------------
module i2p_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  i2p_pkg::stat_t  stat,
  output i2p_pkg::ctrl_t  ctrl
);

  i2p_pkg::step_t  step_r;
  i2p_pkg::step_t  step_nxt;
  i2p_pkg::uword_t uw;
  logic            hit;

  assign uw = i2p_pkg::ucode(step_r);

  always_comb begin
    case (uw.cond)
      i2p_pkg::C_ALWAYS:   hit = 1'b1;
      i2p_pkg::C_EMPTY:    hit = stat.empty;
      i2p_pkg::C_TOP_LPAR: hit = stat.top_lpar;
      i2p_pkg::C_TOP_FN:   hit = stat.top_fn;
      i2p_pkg::C_BIN_POPS: hit = stat.bin_pops;
      i2p_pkg::C_LAST:     hit = stat.last;
      default:             hit = 1'b1;
    endcase
  end

  assign ctrl.idle = (step_r == i2p_pkg::S_IDLE);
  assign ctrl.act  = hit ? uw.act_hit : uw.act_miss;

  always_comb begin
    if (stat.accept) begin
      step_nxt = i2p_pkg::entry_step(stat.in_cls);
    end else if (stat.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = hit ? uw.step_hit : uw.step_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= i2p_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: rtl/i2p_dpath.sv
// ----------------------------------------------------------------------------
// i2p_dpath
// Datapath: token register, operator stack control with cached top entry,
// sticky error, one-deep pending result and output register.
// ----------------------------------------------------------------------------
module i2p_dpath #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  i2p_pkg::ctrl_t                  ctrl,
  output i2p_pkg::stat_t                  stat,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [2:0]                      in_op_code,
  input  logic [3:0]                      in_fn_code,
  input  logic [HANDLE_BITS-1:0]          in_operand,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_kind,
  output logic [2:0]                      out_op,
  output logic [3:0]                      out_fn,
  output logic [HANDLE_BITS-1:0]          out_operand,
  output logic                            out_end_res,
  output logic [1:0]                      out_error,
  output logic                            ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0]  ram_waddr,
  output i2p_pkg::entry_t                 ram_wdata,
  output logic [$clog2(STACK_DEPTH)-1:0]  ram_raddr,
  input  i2p_pkg::entry_t                 ram_rdata
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  function automatic logic pops_for(input logic [2:0] t, input i2p_pkg::entry_t e);
    logic r;
    r = 1'b0;
    if (t == i2p_pkg::OP_ADD || t == i2p_pkg::OP_SUB) begin
      r = 1'b1;
    end else if (t == i2p_pkg::OP_MUL || t == i2p_pkg::OP_DIV) begin
      r = !e[4] && (e[2:0] == i2p_pkg::OP_MUL || e[2:0] == i2p_pkg::OP_DIV ||
                    e[2:0] == i2p_pkg::OP_POW) && !e[3];
    end
    return r;
  endfunction

  // token register
  logic [1:0]             func_r;
  logic [2:0]             op_r;
  logic [3:0]             fn_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic                   last_r;

  // stack control
  logic [CW-1:0]          cnt_r, cnt_nxt;
  i2p_pkg::entry_t        top_r, top_nxt;
  logic [1:0]             err_r, err_nxt;

  // pending result
  logic                   pend_v_r, pend_v_nxt;
  logic [2:0]             pend_kind_r;
  logic [2:0]             pend_op_r;
  logic [3:0]             pend_fn_r;
  logic [HANDLE_BITS-1:0] pend_hnd_r;
  logic [1:0]             pend_err_r;
  i2p_pkg::rcnt_t         n_r, n_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_kind_r;
  logic [2:0]             out_op_r;
  logic [3:0]             out_fn_r;
  logic [HANDLE_BITS-1:0] out_hnd_r;
  logic                   out_end_r;
  logic [1:0]             out_err_r;

  logic                   accept;
  i2p_pkg::cls_t          in_cls;
  logic                   empty;
  logic                   top_lpar;
  logic                   out_free;
  logic                   emit_ok;
  logic                   send;
  logic                   hold;
  logic                   go;
  logic                   is_in;
  i2p_pkg::entry_t        push_e;
  logic [2:0]             new_kind;
  logic [2:0]             new_op;
  logic [3:0]             new_fn;
  logic [HANDLE_BITS-1:0] new_hnd;

  assign accept   = in_valid && ctrl.idle;
  assign in_stall = !ctrl.idle;

  always_comb begin
    case (in_func)
      i2p_pkg::TOK_NUM,
      i2p_pkg::TOK_VAR:  in_cls = i2p_pkg::CLS_OPND;
      i2p_pkg::TOK_FUNC: in_cls = (in_fn_code <= i2p_pkg::FN_MAX) ?
                                  i2p_pkg::CLS_FUNC : i2p_pkg::CLS_NONE;
      default: begin
        case (in_op_code)
          i2p_pkg::OP_ADD,
          i2p_pkg::OP_SUB,
          i2p_pkg::OP_MUL,
          i2p_pkg::OP_DIV,
          i2p_pkg::OP_POW:  in_cls = i2p_pkg::CLS_BIN;
          i2p_pkg::OP_LPAR: in_cls = i2p_pkg::CLS_LPAR;
          i2p_pkg::OP_RPAR: in_cls = i2p_pkg::CLS_RPAR;
          default:          in_cls = i2p_pkg::CLS_NONE;
        endcase
      end
    endcase
  end

  assign empty    = (cnt_r == '0);
  assign top_lpar = !empty && (top_r == {2'b00, i2p_pkg::OP_LPAR});

  assign out_free = !out_valid_r || !out_stall;
  assign is_in    = (ctrl.act == i2p_pkg::A_EMIT_IN);
  assign emit_ok  = (is_in || ctrl.act == i2p_pkg::A_POP_EMIT) &&
                    (n_r < i2p_pkg::MAX_RESULTS);
  assign send     = ((emit_ok || ctrl.act == i2p_pkg::A_DONE) && pend_v_r) ||
                    (ctrl.act == i2p_pkg::A_END);
  assign hold     = send && !out_free;
  assign go       = !hold;

  assign stat.in_cls   = in_cls;
  assign stat.accept   = accept;
  assign stat.empty    = empty;
  assign stat.top_lpar = top_lpar;
  assign stat.top_fn   = !empty && top_r[4];
  assign stat.bin_pops = !empty && !top_lpar && pops_for(op_r, top_r);
  assign stat.last     = last_r;
  assign stat.hold     = hold;

  assign push_e   = (ctrl.act == i2p_pkg::A_PUSH_FN) ? {1'b1, fn_r} : {2'b00, op_r};
  assign new_kind = is_in ? {1'b0, func_r} :
                    (top_r[4] ? i2p_pkg::KIND_FUNC : i2p_pkg::KIND_OPER);
  assign new_op   = (!is_in && !top_r[4]) ? top_r[2:0] : 3'd0;
  assign new_fn   = (!is_in && top_r[4]) ? top_r[3:0] : 4'd0;
  assign new_hnd  = is_in ? hnd_r : '0;

  assign ram_waddr = cnt_r[AW-1:0];
  assign ram_wdata = push_e;
  assign ram_raddr = (cnt_nxt >= CW'(2)) ? AW'(cnt_nxt - CW'(2)) : '0;

  always_comb begin
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    err_nxt    = err_r;
    pend_v_nxt = pend_v_r;
    n_nxt      = n_r;
    ram_we     = 1'b0;
    if (go) begin
      case (ctrl.act)
        i2p_pkg::A_PUSH_FN,
        i2p_pkg::A_PUSH_OP: begin
          if (cnt_r == CW'(STACK_DEPTH)) begin
            if (err_r == i2p_pkg::ERR_NONE) begin
              err_nxt = i2p_pkg::ERR_OVERFLOW;
            end
          end else begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            top_nxt = push_e;
          end
        end
        i2p_pkg::A_POP_EMIT,
        i2p_pkg::A_POP_DROP: begin
          cnt_nxt = cnt_r - CW'(1);
          top_nxt = ram_rdata;
        end
        i2p_pkg::A_POP_ERR3: begin
          cnt_nxt = cnt_r - CW'(1);
          top_nxt = ram_rdata;
          if (err_r == i2p_pkg::ERR_NONE) begin
            err_nxt = i2p_pkg::ERR_OPEN;
          end
        end
        i2p_pkg::A_ERR2: begin
          if (err_r == i2p_pkg::ERR_NONE) begin
            err_nxt = i2p_pkg::ERR_CLOSE;
          end
        end
        i2p_pkg::A_DONE: begin
          pend_v_nxt = 1'b0;
          n_nxt      = '0;
        end
        i2p_pkg::A_END: begin
          pend_v_nxt = 1'b0;
          n_nxt      = '0;
          err_nxt    = i2p_pkg::ERR_NONE;
          cnt_nxt    = '0;
        end
        default: begin
        end
      endcase
      if (emit_ok) begin
        pend_v_nxt = 1'b1;
        n_nxt      = n_r + i2p_pkg::rcnt_t'(1);
      end
    end
  end

  assign out_valid_nxt = (send && go) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= i2p_pkg::ERR_NONE;
      pend_v_r    <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      pend_v_r    <= pend_v_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (accept) begin
      func_r <= in_func;
      op_r   <= in_op_code;
      fn_r   <= in_fn_code;
      hnd_r  <= in_operand;
      last_r <= in_last;
    end
    if (go && emit_ok) begin
      pend_kind_r <= new_kind;
      pend_op_r   <= new_op;
      pend_fn_r   <= new_fn;
      pend_hnd_r  <= new_hnd;
      pend_err_r  <= err_r;
    end
    if (go && send) begin
      if (ctrl.act == i2p_pkg::A_END && !pend_v_r) begin
        out_kind_r <= i2p_pkg::KIND_END;
        out_op_r   <= 3'd0;
        out_fn_r   <= 4'd0;
        out_hnd_r  <= '0;
      end else begin
        out_kind_r <= pend_kind_r;
        out_op_r   <= pend_op_r;
        out_fn_r   <= pend_fn_r;
        out_hnd_r  <= pend_hnd_r;
      end
      out_end_r <= (ctrl.act == i2p_pkg::A_END);
      out_err_r <= (ctrl.act == i2p_pkg::A_END) ? err_r : pend_err_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_op      = out_op_r;
  assign out_fn      = out_fn_r;
  assign out_operand = out_hnd_r;
  assign out_end_res = out_end_r;
  assign out_error   = out_err_r;

endmodule

FILE: rtl/i2p_checker.sv
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2p_checker #(
  parameter int unsigned HANDLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [2:0]             out_kind,
  input logic [HANDLE_BITS-1:0] out_operand,
  input logic                   out_end_res,
  input logic [1:0]             out_error
);

  // hold a stalled item
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_kind) && $stable(out_operand) && $stable(out_end_res) && $stable(out_error))
  // an end marker always closes the expression
  `ASSERT_CLK(a_end_mark, clk, rst_n, out_valid && out_kind == i2p_pkg::KIND_END |-> out_end_res)
  // drop output on reset
  `ASSERT_CLK_NR(a_reset_idle, clk, !rst_n |=> !out_valid && !in_stall)

endmodule

bind infix_to_postfix_converter i2p_checker #(
  .HANDLE_BITS (HANDLE_BITS)
) u_i2p_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_kind    (out_kind),
  .out_operand (out_operand),
  .out_end_res (out_end_res),
  .out_error   (out_error)
);

FILE: tb/sv/tb_infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Feeds infix tokens to the converter and checks every postfix token against
// a shunting-yard predictor held in the testbench. A directed part covers
// precedence, right-associative power, functions around parentheses, invalid
// codes, unmatched ')' and '('. Random expressions, deep nests, power
// chains, broken sequences and noise follow. Both channels idle at random,
// and the output holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned HBITS       = 16;
  localparam int unsigned RAND_ITEMS  = 410;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam logic [2:0]  OP_BAD      = 3'd7;
  localparam logic [3:0]  FN_NEG      = 4'd4;
  localparam logic [3:0]  FN_BAD      = 4'd15;

  typedef struct packed {
    logic [1:0]       func;
    logic [2:0]       op;
    logic [3:0]       fn;
    logic [HBITS-1:0] operand;
    logic             last;
  } infix_tok_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       op;
    logic [3:0]       fn;
    logic [HBITS-1:0] operand;
    logic             end_res;
    logic [1:0]       error;
  } postfix_tok_t;

  class postfix_predictor;
    i2p_pkg::entry_t op_stack[$];
    logic [1:0]      err_flag = i2p_pkg::ERR_NONE;
    postfix_tok_t    due[$];
    int unsigned     n_bad = 0;

    function void set_err(logic [1:0] code);
      if (err_flag == i2p_pkg::ERR_NONE) err_flag = code;
    endfunction

    function void push(i2p_pkg::entry_t e);
      if (op_stack.size() >= DEPTH) set_err(i2p_pkg::ERR_OVERFLOW);
      else op_stack.insert(op_stack.size(), e);
    endfunction

    function bit is_lpar(i2p_pkg::entry_t e);
      return e == {2'b00, i2p_pkg::OP_LPAR};
    endfunction

    function bit yields(logic [2:0] opc, i2p_pkg::entry_t top);
      if (opc == i2p_pkg::OP_ADD || opc == i2p_pkg::OP_SUB) return 1'b1;
      if (opc == i2p_pkg::OP_MUL || opc == i2p_pkg::OP_DIV)
        return !top[4] && !top[3] &&
               (top[2:0] == i2p_pkg::OP_MUL || top[2:0] == i2p_pkg::OP_DIV ||
                top[2:0] == i2p_pkg::OP_POW);
      return 1'b0;
    endfunction

    function postfix_tok_t from_entry(i2p_pkg::entry_t e);
      postfix_tok_t r;
      r = '0;
      r.error = err_flag;
      if (e[4]) begin
        r.kind = i2p_pkg::KIND_FUNC;
        r.fn = e[3:0];
      end else begin
        r.kind = i2p_pkg::KIND_OPER;
        r.op = e[2:0];
      end
      return r;
    endfunction

    function void take_token(infix_tok_t t);
      postfix_tok_t    outs[$];
      postfix_tok_t    r;
      i2p_pkg::entry_t top;
      bit              found;
      found = 1'b0;
      if (t.func == i2p_pkg::TOK_NUM || t.func == i2p_pkg::TOK_VAR) begin
        r = '0;
        r.kind = (t.func == i2p_pkg::TOK_NUM) ? i2p_pkg::KIND_NUM : i2p_pkg::KIND_VAR;
        r.operand = t.operand;
        r.error = err_flag;
        outs.insert(outs.size(), r);
      end else if (t.func == i2p_pkg::TOK_FUNC) begin
        if (t.fn <= i2p_pkg::FN_MAX) push({1'b1, t.fn});
      end else if (t.op <= i2p_pkg::OP_POW) begin
        while (op_stack.size() > 0 && !is_lpar(op_stack[op_stack.size()-1]) &&
               yields(t.op, op_stack[op_stack.size()-1]))
          outs.insert(outs.size(), from_entry(op_stack.pop_back()));
        push({2'b00, t.op});
      end else if (t.op == i2p_pkg::OP_LPAR) begin
        push({2'b00, i2p_pkg::OP_LPAR});
      end else if (t.op == i2p_pkg::OP_RPAR) begin
        while (op_stack.size() > 0 && !found) begin
          top = op_stack.pop_back();
          if (is_lpar(top)) found = 1'b1;
          else outs.insert(outs.size(), from_entry(top));
        end
        if (!found) begin
          set_err(i2p_pkg::ERR_CLOSE);
        end else if (op_stack.size() > 0) begin
          top = op_stack[op_stack.size()-1];
          if (top[4]) outs.insert(outs.size(), from_entry(op_stack.pop_back()));
        end
      end
      if (t.last) begin
        while (op_stack.size() > 0) begin
          top = op_stack.pop_back();
          if (is_lpar(top)) set_err(i2p_pkg::ERR_OPEN);
          else outs.insert(outs.size(), from_entry(top));
        end
        if (outs.size() == 0) begin
          r = '0;
          r.kind = i2p_pkg::KIND_END;
          outs.insert(outs.size(), r);
        end
        r = outs.pop_back();
        r.end_res = 1'b1;
        r.error = err_flag;
        outs.insert(outs.size(), r);
        err_flag = i2p_pkg::ERR_NONE;
      end
      foreach (outs[i]) due.insert(due.size(), outs[i]);
    endfunction

    function string show(postfix_tok_t r);
      return $sformatf("kind %0d op %0d fn %0d operand %h end %0b err %0d",
                       r.kind, r.op, r.fn, r.operand, r.end_res, r.error);
    endfunction

    function void match_result(postfix_tok_t got);
      postfix_tok_t want;
      if (due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind || got.op !== want.op || got.fn !== want.fn ||
          got.operand !== want.operand || got.end_res !== want.end_res ||
          got.error !== want.error) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("result mismatch: expected %s", show(want));
          $display("                 actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_func = i2p_pkg::TOK_NUM;
  logic [2:0]       in_op_code = i2p_pkg::OP_ADD;
  logic [3:0]       in_fn_code = 4'd0;
  logic [HBITS-1:0] in_operand = '0;
  logic             in_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_kind;
  logic [2:0]       out_op;
  logic [3:0]       out_fn;
  logic [HBITS-1:0] out_operand;
  logic             out_end_res;
  logic [1:0]       out_error;

  postfix_predictor pred = new;
  int unsigned      n_taken = 0;
  int unsigned      quiet = 0;
  int unsigned      n_offered = 0;
  bit               held = 1'b0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(DEPTH),
    .HANDLE_BITS(HBITS)
  ) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit steady_phase();
    return n_taken >= 250 && n_taken < 330;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        pred.match_result(postfix_tok_t'{out_kind, out_op, out_fn, out_operand,
                                         out_end_res, out_error});
      if (in_valid && !in_stall) begin
        pred.take_token(infix_tok_t'{in_func, in_op_code, in_fn_code, in_operand, in_last});
        n_taken <= n_taken + 1;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet <= 0;
      end else if (quiet + 1 >= STUCK_LIMIT) begin
        $display("tb_infix_to_postfix_converter: done, errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // hold the output once while the sender keeps offering items
  initial begin
    forever begin
      @(posedge clk);
      if (!held && n_taken >= 120) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      out_stall <= !steady_phase() && ($urandom_range(99) < 11);
    end
  end

  function automatic infix_tok_t mk_tok(input logic [1:0] func, input logic [15:0] val);
    infix_tok_t t;
    t.func = func;
    t.op = 3'($urandom_range(7));
    t.fn = 4'($urandom_range(15));
    t.operand = HBITS'($urandom);
    t.last = 1'b0;
    case (func)
      i2p_pkg::TOK_FUNC: t.fn = val[3:0];
      i2p_pkg::TOK_OPER: t.op = val[2:0];
      default:           t.operand = val;
    endcase
    return t;
  endfunction

  function automatic infix_tok_t op_tok(input logic [2:0] op);
    return mk_tok(i2p_pkg::TOK_OPER, {13'd0, op});
  endfunction

  function automatic infix_tok_t fn_tok(input logic [3:0] fn);
    return mk_tok(i2p_pkg::TOK_FUNC, {12'd0, fn});
  endfunction

  function automatic infix_tok_t any_fn();
    return fn_tok(4'($urandom_range(i2p_pkg::FN_MAX)));
  endfunction

  function automatic void add_tok(ref infix_tok_t seq[$], input infix_tok_t t);
    seq.insert(seq.size(), t);
  endfunction

  function automatic void build_expr(ref infix_tok_t seq[$], input int unsigned n_opnd);
    int unsigned open;
    open = 0;
    for (int unsigned k = 0; k < n_opnd; k++) begin
      while ($urandom_range(99) < 25 && open < 6) begin
        if ($urandom_range(1)) add_tok(seq, any_fn());
        add_tok(seq, op_tok(i2p_pkg::OP_LPAR));
        open++;
      end
      if ($urandom_range(99) < 10) add_tok(seq, any_fn());
      add_tok(seq, mk_tok(2'($urandom_range(1)), 16'($urandom)));
      while (open > 0 && $urandom_range(99) < 30) begin
        add_tok(seq, op_tok(i2p_pkg::OP_RPAR));
        open--;
      end
      if (k + 1 < n_opnd) add_tok(seq, op_tok(3'($urandom_range(i2p_pkg::OP_POW))));
    end
    repeat (open) add_tok(seq, op_tok(i2p_pkg::OP_RPAR));
  endfunction

  task automatic send_token(input infix_tok_t t);
    while (!steady_phase() && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= t.func;
    in_op_code <= t.op;
    in_fn_code <= t.fn;
    in_operand <= t.operand;
    in_last    <= t.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (t.last || !((t.func == i2p_pkg::TOK_FUNC && t.fn > i2p_pkg::FN_MAX) ||
                    (t.func == i2p_pkg::TOK_OPER && t.op == OP_BAD)))
      n_offered++;
  endtask

  task automatic send_seq(ref infix_tok_t seq[$], input bit mark_end);
    infix_tok_t t;
    if (mark_end && seq.size() > 0) begin
      t = seq.pop_back();
      t.last = 1'b1;
      add_tok(seq, t);
    end
    foreach (seq[i]) send_token(seq[i]);
    seq.delete();
  endtask

  initial begin
    infix_tok_t  seq[$];
    infix_tok_t  t;
    int unsigned pick;
    int unsigned k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // precedence, right-associative power, handle extremes
    add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'hFFFF));
    add_tok(seq, op_tok(i2p_pkg::OP_SUB));
    add_tok(seq, mk_tok(i2p_pkg::TOK_VAR, 16'h0000));
    add_tok(seq, op_tok(i2p_pkg::OP_MUL));
    add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'h1234));
    add_tok(seq, op_tok(i2p_pkg::OP_POW));
    add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'h0002));
    add_tok(seq, op_tok(i2p_pkg::OP_POW));
    add_tok(seq, mk_tok(i2p_pkg::TOK_VAR, 16'h0003));
    add_tok(seq, op_tok(i2p_pkg::OP_DIV));
    add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'h0007));
    send_seq(seq, 1'b1);
    // function around parentheses, bare function popped by addition
    add_tok(seq, fn_tok(i2p_pkg::FN_MAX));
    add_tok(seq, op_tok(i2p_pkg::OP_LPAR));
    add_tok(seq, mk_tok(i2p_pkg::TOK_VAR, 16'h0005));
    add_tok(seq, op_tok(i2p_pkg::OP_RPAR));
    add_tok(seq, op_tok(i2p_pkg::OP_MUL));
    add_tok(seq, fn_tok(FN_NEG));
    add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'h0009));
    add_tok(seq, op_tok(i2p_pkg::OP_ADD));
    add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'h0001));
    send_seq(seq, 1'b1);
    // unmatched close, unmatched open, invalid codes with empty end
    add_tok(seq, op_tok(i2p_pkg::OP_RPAR));
    send_seq(seq, 1'b1);
    add_tok(seq, op_tok(i2p_pkg::OP_LPAR));
    add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'h8000));
    send_seq(seq, 1'b1);
    add_tok(seq, op_tok(OP_BAD));
    add_tok(seq, fn_tok(FN_BAD));
    send_seq(seq, 1'b1);

    n_offered = 0;
    while (n_offered < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        build_expr(seq, $urandom_range(1, 8));
        send_seq(seq, 1'b1);
      end else if (pick < 65) begin
        k = $urandom_range(30, 34);
        add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'($urandom)));
        repeat (k - 1) begin
          add_tok(seq, op_tok(i2p_pkg::OP_POW));
          add_tok(seq, mk_tok(i2p_pkg::TOK_VAR, 16'($urandom)));
        end
        send_seq(seq, 1'b1);
      end else if (pick < 69) begin
        repeat ($urandom_range(30, 35)) begin
          if ($urandom_range(3) == 0) add_tok(seq, any_fn());
          else add_tok(seq, op_tok(i2p_pkg::OP_LPAR));
        end
        add_tok(seq, mk_tok(i2p_pkg::TOK_NUM, 16'($urandom)));
        repeat ($urandom_range(0, 36)) add_tok(seq, op_tok(i2p_pkg::OP_RPAR));
        send_seq(seq, 1'b1);
      end else if (pick < 85) begin
        build_expr(seq, $urandom_range(1, 6));
        k = $urandom_range(seq.size() - 1);
        case ($urandom_range(2))
          0: seq.delete(k);
          1: seq.insert(k, op_tok(3'($urandom_range(i2p_pkg::OP_LPAR, i2p_pkg::OP_RPAR))));
          default: while (seq.size() > k + 1) void'(seq.pop_back());
        endcase
        send_seq(seq, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          t.func = 2'($urandom_range(3));
          t.op = 3'($urandom_range(7));
          t.fn = 4'($urandom_range(15));
          t.operand = HBITS'($urandom);
          t.last = ($urandom_range(4) == 0);
          add_tok(seq, t);
        end
        send_seq(seq, 1'b0);
      end
    end
    in_valid <= 1'b0;

    // drain
    while (pred.due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pred.n_bad == 0 && pred.due.size() == 0)
      $display("tb_infix_to_postfix_converter: done, clean");
    else
      $display("tb_infix_to_postfix_converter: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/i2p_pkg.sv
rtl/i2p_ram.sv
rtl/i2p_seq.sv
rtl/i2p_dpath.sv
rtl/infix_to_postfix_converter.sv
rtl/i2p_checker.sv
tb/sv/tb_infix_to_postfix_converter.sv
